// ===== rtl/snpid_pkg.sv =====
// Package with shared types, widths and a saturation helper of the adaptive PID neuron.
`timescale 1ns / 1ps
`default_nettype none
package snpid_pkg;

	localparam int DATA_W = 32;
	localparam int PROD_W = 64;
	localparam int ACC_W  = 66;
	localparam int DEN_W  = 34;
	localparam int ADDR_W = 5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_EC,
		ST_VAR,
		ST_MUL,
		ST_WB,
		ST_ABS,
		ST_DIV,
		ST_DIVWAIT,
		ST_CLAMP,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		STEP_HEBB,
		STEP_GP,
		STEP_DP,
		STEP_GI,
		STEP_DI,
		STEP_GD,
		STEP_DD,
		STEP_TP,
		STEP_TI,
		STEP_TD,
		STEP_NUM
	} step_t;

	typedef enum logic [2:0] {
		REG_GAIN_K,
		REG_RATE_P,
		REG_RATE_I,
		REG_RATE_D,
		REG_WINIT_P,
		REG_WINIT_I,
		REG_WINIT_D
	} reg_idx_t;

	typedef struct packed {
		logic                     start;
		logic signed [PROD_W-1:0] num;
		logic        [DEN_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [PROD_W-1:0] quot;
	} div_rsp_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(signed'(32'sh7fffffff));
		lo = ACC_W'(signed'(32'sh80000000));
		if (v > hi) begin
			sat32 = 32'sh7fffffff;
		end else if (v < lo) begin
			sat32 = 32'sh80000000;
		end else begin
			sat32 = v[DATA_W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

// ===== rtl/snpid_if.sv =====
// Valid/ready channel interfaces for the input samples and the drive results.
`timescale 1ns / 1ps
`default_nettype none
interface snpid_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [snpid_pkg::DATA_W-1:0]   setpoint;
	logic signed [snpid_pkg::DATA_W-1:0]   feedback;
	modport source (output valid, output setpoint, output feedback, input ready);
	modport sink (input valid, input setpoint, input feedback, output ready);
endinterface

interface snpid_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [snpid_pkg::DATA_W-1:0]   drive;
	logic                                  zero_weight_sum;
	modport source (output valid, output drive, output zero_weight_sum, input ready);
	modport sink (input valid, input drive, input zero_weight_sum, output ready);
endinterface
`default_nettype wire

// ===== rtl/single_neuron_adaptive_pid.sv =====
// Top level of the single-neuron adaptive PID controller with its sequencer and register port.
// From an accepted sample to its drive result beat on the division path: 3 difference steps,
// 11 multiply and write-back pairs on one shared 32x32 multiplier, then a bit-serial division.
// A new sample is taken only in idle, after the previous result beat has been accepted.
// A zero absolute weight sum skips the last multiply and the division and gives drive zero.
// Reset (arst_n, async) sets gain_k to 1.0 and other config, weights, history, state to zero.
`timescale 1ns / 1ps
`default_nettype none
module single_neuron_adaptive_pid #(
	parameter int OUT_MIN   = -6553600,
	parameter int OUT_MAX   = 6553600,
	parameter int FRAC_BITS = 16
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	snpid_in_if.sink                            sample,
	snpid_out_if.source                         result,
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire  [snpid_pkg::ADDR_W-1:0]        paddr,
	input  wire  [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	localparam int DW = snpid_pkg::DATA_W;
	localparam int PW = snpid_pkg::PROD_W;
	localparam int AW = snpid_pkg::ACC_W;

	snpid_pkg::state_t state_q, state_d;
	snpid_pkg::step_t  step_q;
	snpid_pkg::reg_idx_t widx;

	logic signed [DW-1:0] gain_q, rate_p_q, rate_i_q, rate_d_q;
	logic signed [DW-1:0] winit_p_q, winit_i_q, winit_d_q;
	logic signed [DW-1:0] wp_q, wi_q, wd_q;
	logic signed [DW-1:0] pdrive_q, perr_q, pchg_q, pvar_q;
	logic signed [DW-1:0] sp_q, fb_q, err_q, ec_q, var_q, hebb_q, g_q, s_q;
	logic signed [DW-1:0] drive_q;
	logic                 flag_q;
	logic signed [PW-1:0] prod_q;
	logic signed [AW-1:0] acc_q;
	logic signed [DW-1:0] op_a, op_b;
	logic signed [PW-1:0] shifted;
	logic signed [DW-1:0] sh_sat;
	logic signed [DW-1:0] wsel;
	logic signed [DW-1:0] wnew;
	logic [snpid_pkg::DEN_W-1:0] abs_sum;
	logic signed [PW-1:0] lo_lim, hi_lim;
	logic signed [PW-1:0] clamped;
	logic                 cfg_wr;

	snpid_pkg::div_req_t div_req;
	snpid_pkg::div_rsp_t div_rsp;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign widx   = snpid_pkg::reg_idx_t'(paddr[4:2]);

	always_comb begin
		case (snpid_pkg::reg_idx_t'(paddr[4:2]))
			snpid_pkg::REG_GAIN_K:  prdata = gain_q;
			snpid_pkg::REG_RATE_P:  prdata = rate_p_q;
			snpid_pkg::REG_RATE_I:  prdata = rate_i_q;
			snpid_pkg::REG_RATE_D:  prdata = rate_d_q;
			snpid_pkg::REG_WINIT_P: prdata = winit_p_q;
			snpid_pkg::REG_WINIT_I: prdata = winit_i_q;
			snpid_pkg::REG_WINIT_D: prdata = winit_d_q;
			default:                prdata = '0;
		endcase
	end

	always_comb begin
		case (step_q)
			snpid_pkg::STEP_HEBB: begin op_a = err_q;    op_b = pdrive_q; end
			snpid_pkg::STEP_GP:   begin op_a = rate_p_q; op_b = hebb_q;   end
			snpid_pkg::STEP_DP:   begin op_a = g_q;      op_b = pchg_q;   end
			snpid_pkg::STEP_GI:   begin op_a = rate_i_q; op_b = hebb_q;   end
			snpid_pkg::STEP_DI:   begin op_a = g_q;      op_b = perr_q;   end
			snpid_pkg::STEP_GD:   begin op_a = rate_d_q; op_b = hebb_q;   end
			snpid_pkg::STEP_DD:   begin op_a = g_q;      op_b = pvar_q;   end
			snpid_pkg::STEP_TP:   begin op_a = wp_q;     op_b = ec_q;     end
			snpid_pkg::STEP_TI:   begin op_a = wi_q;     op_b = err_q;    end
			snpid_pkg::STEP_TD:   begin op_a = wd_q;     op_b = var_q;    end
			snpid_pkg::STEP_NUM:  begin op_a = gain_q;   op_b = s_q;      end
			default:              begin op_a = '0;       op_b = '0;       end
		endcase
	end

	always_comb begin
		shifted = prod_q >>> FRAC_BITS;
		sh_sat  = snpid_pkg::sat32(AW'(shifted));
		case (step_q)
			snpid_pkg::STEP_DP: wsel = wp_q;
			snpid_pkg::STEP_DI: wsel = wi_q;
			default:            wsel = wd_q;
		endcase
		wnew    = snpid_pkg::sat32(AW'(wsel) + AW'(sh_sat));
		abs_sum = snpid_pkg::DEN_W'(wp_q[DW-1] ? -AW'(wp_q) : AW'(wp_q))
		        + snpid_pkg::DEN_W'(wi_q[DW-1] ? -AW'(wi_q) : AW'(wi_q))
		        + snpid_pkg::DEN_W'(wd_q[DW-1] ? -AW'(wd_q) : AW'(wd_q));
		lo_lim  = PW'(signed'(DW'(OUT_MIN)));
		hi_lim  = PW'(signed'(DW'(OUT_MAX)));
		clamped = (div_rsp.quot < lo_lim) ? lo_lim : div_rsp.quot;
		if (clamped > hi_lim) begin
			clamped = hi_lim;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			snpid_pkg::ST_IDLE:    if (sample.valid) state_d = snpid_pkg::ST_ERR;
			snpid_pkg::ST_ERR:     state_d = snpid_pkg::ST_EC;
			snpid_pkg::ST_EC:      state_d = snpid_pkg::ST_VAR;
			snpid_pkg::ST_VAR:     state_d = snpid_pkg::ST_MUL;
			snpid_pkg::ST_MUL:     state_d = snpid_pkg::ST_WB;
			snpid_pkg::ST_WB: begin
				if (step_q == snpid_pkg::STEP_TD) begin
					state_d = snpid_pkg::ST_ABS;
				end else if (step_q == snpid_pkg::STEP_NUM) begin
					state_d = snpid_pkg::ST_DIV;
				end else begin
					state_d = snpid_pkg::ST_MUL;
				end
			end
			snpid_pkg::ST_ABS: begin
				state_d = (abs_sum == '0) ? snpid_pkg::ST_OUT : snpid_pkg::ST_MUL;
			end
			snpid_pkg::ST_DIV:     state_d = snpid_pkg::ST_DIVWAIT;
			snpid_pkg::ST_DIVWAIT: if (div_rsp.done) state_d = snpid_pkg::ST_CLAMP;
			snpid_pkg::ST_CLAMP:   state_d = snpid_pkg::ST_OUT;
			snpid_pkg::ST_OUT:     if (result.ready) state_d = snpid_pkg::ST_IDLE;
			default:               state_d = snpid_pkg::ST_IDLE;
		endcase
	end

	assign sample.ready           = (state_q == snpid_pkg::ST_IDLE);
	assign result.valid           = (state_q == snpid_pkg::ST_OUT);
	assign result.drive           = drive_q;
	assign result.zero_weight_sum = flag_q;

	assign div_req.start = (state_q == snpid_pkg::ST_DIV);
	assign div_req.num   = prod_q;
	assign div_req.den   = abs_sum;

	snpid_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= snpid_pkg::ST_IDLE;
			step_q    <= snpid_pkg::STEP_HEBB;
			gain_q    <= 32'sd65536;
			rate_p_q  <= '0;
			rate_i_q  <= '0;
			rate_d_q  <= '0;
			winit_p_q <= '0;
			winit_i_q <= '0;
			winit_d_q <= '0;
			wp_q      <= '0;
			wi_q      <= '0;
			wd_q      <= '0;
			pdrive_q  <= '0;
			perr_q    <= '0;
			pchg_q    <= '0;
			pvar_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				case (widx)
					snpid_pkg::REG_GAIN_K: gain_q <= pwdata;
					snpid_pkg::REG_RATE_P: rate_p_q <= pwdata;
					snpid_pkg::REG_RATE_I: rate_i_q <= pwdata;
					snpid_pkg::REG_RATE_D: rate_d_q <= pwdata;
					snpid_pkg::REG_WINIT_P: begin
						winit_p_q <= pwdata;
						wp_q      <= pwdata;
					end
					snpid_pkg::REG_WINIT_I: begin
						winit_i_q <= pwdata;
						wi_q      <= pwdata;
					end
					snpid_pkg::REG_WINIT_D: begin
						winit_d_q <= pwdata;
						wd_q      <= pwdata;
					end
					default: ;
				endcase
			end
			case (state_q)
				snpid_pkg::ST_IDLE: step_q <= snpid_pkg::STEP_HEBB;
				snpid_pkg::ST_WB: begin
					case (step_q)
						snpid_pkg::STEP_DP: wp_q <= wnew;
						snpid_pkg::STEP_DI: wi_q <= wnew;
						snpid_pkg::STEP_DD: wd_q <= wnew;
						default: ;
					endcase
					if (step_q != snpid_pkg::STEP_NUM) begin
						step_q <= snpid_pkg::step_t'(step_q + 4'd1);
					end
				end
				snpid_pkg::ST_ABS: begin
					if (abs_sum == '0) begin
						pdrive_q <= '0;
						perr_q   <= err_q;
						pchg_q   <= ec_q;
						pvar_q   <= var_q;
					end
				end
				snpid_pkg::ST_CLAMP: begin
					pdrive_q <= clamped[DW-1:0];
					perr_q   <= err_q;
					pchg_q   <= ec_q;
					pvar_q   <= var_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			snpid_pkg::ST_IDLE: begin
				sp_q <= sample.setpoint;
				fb_q <= sample.feedback;
			end
			snpid_pkg::ST_ERR: err_q <= snpid_pkg::sat32(AW'(sp_q) - AW'(fb_q));
			snpid_pkg::ST_EC:  ec_q  <= snpid_pkg::sat32(AW'(err_q) - AW'(perr_q));
			snpid_pkg::ST_VAR: var_q <= snpid_pkg::sat32(AW'(ec_q) - AW'(pchg_q));
			snpid_pkg::ST_MUL: prod_q <= op_a * op_b;
			snpid_pkg::ST_WB: begin
				case (step_q)
					snpid_pkg::STEP_HEBB: hebb_q <= sh_sat;
					snpid_pkg::STEP_GP,
					snpid_pkg::STEP_GI,
					snpid_pkg::STEP_GD:   g_q <= sh_sat;
					snpid_pkg::STEP_TP:   acc_q <= AW'(shifted);
					snpid_pkg::STEP_TI,
					snpid_pkg::STEP_TD:   acc_q <= acc_q + AW'(shifted);
					default: ;
				endcase
			end
			snpid_pkg::ST_ABS: begin
				s_q     <= snpid_pkg::sat32(acc_q);
				drive_q <= '0;
				flag_q  <= (abs_sum == '0);
			end
			snpid_pkg::ST_CLAMP: begin
				drive_q <= clamped[DW-1:0];
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/snpid_div.sv =====
// Bit-serial restoring divider: signed 64-bit numerator by unsigned divisor, truncating.
`timescale 1ns / 1ps
`default_nettype none
module snpid_div (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire snpid_pkg::div_req_t req,
	output snpid_pkg::div_rsp_t  rsp
);

	localparam int PW = snpid_pkg::PROD_W;
	localparam int DW = snpid_pkg::DEN_W;
	localparam int CW = $clog2(PW + 1);

	logic [PW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          qbit;

	always_comb begin
		trial = {rem_q, quo_q[PW-1]};
		diff  = trial - {1'b0, den_q};
		qbit  = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= CW'(PW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num[PW-1] ? PW'(-req.num) : req.num;
			neg_q <= req.num[PW-1];
			den_q <= req.den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= qbit ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[PW-2:0], qbit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the single-neuron adaptive PID controller.
`timescale 1ns / 1ps
`default_nettype none

class pid_scoreboard;
	int unsigned mismatches;
	logic signed [31:0] drive_q[$];
	logic zero_q[$];
	logic signed [63:0] gain_k, rate_p, rate_i, rate_d;
	logic signed [63:0] w_p, w_i, w_d;
	logic signed [63:0] last_drive, last_err, last_ec, last_var;

	function new();
		mismatches = 0;
		gain_k = 65536;
		rate_p = 0;
		rate_i = 0;
		rate_d = 0;
		w_p = 0;
		w_i = 0;
		w_d = 0;
		last_drive = 0;
		last_err = 0;
		last_ec = 0;
		last_var = 0;
	endfunction

	static function logic signed [63:0] clip32(logic signed [63:0] v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	static function logic signed [63:0] fmul(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [63:0] p;
		p = a * b;
		return p >>> 16;
	endfunction

	static function logic signed [63:0] mag(logic signed [63:0] v);
		return (v < 0) ? -v : v;
	endfunction

	static function logic signed [63:0] adapt(logic signed [63:0] w, logic signed [63:0] r,
			logic signed [63:0] h, logic signed [63:0] x);
		logic signed [63:0] g;
		g = clip32(fmul(r, h));
		return clip32(w + clip32(fmul(g, x)));
	endfunction

	function void write_reg(snpid_pkg::reg_idx_t idx, logic [31:0] v);
		logic signed [63:0] s;
		s = 64'(signed'(v));
		case (idx)
			snpid_pkg::REG_GAIN_K: gain_k = s;
			snpid_pkg::REG_RATE_P: rate_p = s;
			snpid_pkg::REG_RATE_I: rate_i = s;
			snpid_pkg::REG_RATE_D: rate_d = s;
			snpid_pkg::REG_WINIT_P: w_p = s;
			snpid_pkg::REG_WINIT_I: w_i = s;
			snpid_pkg::REG_WINIT_D: w_d = s;
			default: ;
		endcase
	endfunction

	function void note_sample(logic signed [31:0] sp, logic signed [31:0] fb);
		logic signed [63:0] err, ec, dv, hebb, asum, s, q;
		err = clip32(64'(sp) - 64'(fb));
		ec = clip32(err - last_err);
		dv = clip32(ec - last_ec);
		hebb = clip32(fmul(err, last_drive));
		w_p = adapt(w_p, rate_p, hebb, last_ec);
		w_i = adapt(w_i, rate_i, hebb, last_err);
		w_d = adapt(w_d, rate_d, hebb, last_var);
		asum = mag(w_p) + mag(w_i) + mag(w_d);
		if (asum == 0) begin
			q = 0;
			zero_q.push_back(1'b1);
		end else begin
			s = clip32(fmul(w_p, ec) + fmul(w_i, err) + fmul(w_d, dv));
			q = (gain_k * s) / asum;
			if (q < -64'sd6553600) q = -64'sd6553600;
			if (q > 64'sd6553600) q = 64'sd6553600;
			zero_q.push_back(1'b0);
		end
		drive_q.push_back(q[31:0]);
		last_drive = q;
		last_var = dv;
		last_err = err;
		last_ec = ec;
	endfunction

	function void check_result(logic signed [31:0] drv, logic zws);
		logic signed [31:0] e_drv;
		logic e_zws;
		if (drive_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("Unexpected result beat: drive=%0d flag=%0b", drv, zws);
			return;
		end
		e_drv = drive_q.pop_front();
		e_zws = zero_q.pop_front();
		if (drv !== e_drv || zws !== e_zws) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Result mismatch: expected drive=%0d flag=%0b, got drive=%0d flag=%0b",
					e_drv, e_zws, drv, zws);
		end
	endfunction
endclass

module tb;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [snpid_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic calm = 1'b0;
	logic hold_result = 1'b0;
	int unsigned idle_cycles = 0;
	pid_scoreboard board;

	snpid_in_if sample ();
	snpid_out_if result ();

	single_neuron_adaptive_pid dut (
		.clk(clk), .arst_n(arst_n), .sample(sample.sink), .result(result.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	initial begin
		sample.valid = 1'b0;
		sample.setpoint = '0;
		sample.feedback = '0;
		result.ready = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result.valid && result.ready) board.check_result(result.drive, result.zero_weight_sum);
			if ((sample.valid && sample.ready) || (result.valid && result.ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= 20000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int n;
		board = new();
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_result) begin
				result.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 16);
				result.ready <= 1'b0;
				repeat (n - 1) @(posedge clk);
				result.ready <= 1'b1;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(snpid_pkg::reg_idx_t idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= snpid_pkg::ADDR_W'(4 * int'(idx));
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		board.write_reg(idx, v);
	endtask

	task automatic send(logic signed [31:0] sp, logic signed [31:0] fb);
		int n;
		if (!calm && $urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 16);
			sample.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		sample.valid <= 1'b1;
		sample.setpoint <= sp;
		sample.feedback <= fb;
		do @(posedge clk); while (!sample.ready);
		board.note_sample(sp, fb);
	endtask

	task automatic drain();
		sample.valid <= 1'b0;
		while (board.drive_q.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 1) ? 32'(int'($urandom_range(0, 400000)))
				: -32'(int'($urandom_range(0, 400000)));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_weight();
		return $urandom_range(0, 3) == 0 ? rand_word()
			: 32'(int'($urandom_range(0, 131072)) - 65536);
	endfunction

	task automatic random_phase(int count, bit wild);
		logic signed [31:0] sp;
		for (int k = 0; k < count; k++) begin
			sp = wild ? rand_word() : 32'(int'($urandom_range(0, 655360)) - 327680);
			send(sp, wild ? rand_word() : sp + 32'(int'($urandom_range(0, 65536)) - 32768));
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(32'sd100, 32'sd0);
		drain();
		write_reg(snpid_pkg::REG_WINIT_P, 32'h00010000);
		write_reg(snpid_pkg::REG_WINIT_I, 32'h00008000);
		write_reg(snpid_pkg::REG_WINIT_D, 32'h00004000);
		write_reg(snpid_pkg::REG_RATE_P, 32'h00000100);
		write_reg(snpid_pkg::REG_RATE_I, 32'h00000080);
		write_reg(snpid_pkg::REG_RATE_D, 32'h00000040);
		write_reg(snpid_pkg::REG_GAIN_K, 32'h00020000);
		send(32'h7fffffff, 32'h80000000);
		send(32'h80000000, 32'h7fffffff);
		send(32'h7fffffff, 32'h7fffffff);
		send(32'h80000000, 32'h00000000);
		send(32'h00000000, 32'h00000000);
		send(32'h00010000, 32'hffff0000);
		send(32'hffffffff, 32'h00000001);
		drain();
		write_reg(snpid_pkg::REG_GAIN_K, 32'h7fffffff);
		write_reg(snpid_pkg::REG_RATE_P, 32'h80000000);
		write_reg(snpid_pkg::REG_RATE_I, 32'h7fffffff);
		write_reg(snpid_pkg::REG_RATE_D, 32'h80000000);
		write_reg(snpid_pkg::REG_WINIT_P, 32'h80000000);
		write_reg(snpid_pkg::REG_WINIT_I, 32'h7fffffff);
		write_reg(snpid_pkg::REG_WINIT_D, 32'h80000000);
		send(32'h00050000, 32'h00010000);
		send(32'hfffb0000, 32'h00010000);
		send(32'h7fffffff, 32'h80000000);
		drain();
		write_reg(snpid_pkg::REG_WINIT_P, 32'h0);
		write_reg(snpid_pkg::REG_WINIT_I, 32'h0);
		write_reg(snpid_pkg::REG_WINIT_D, 32'h0);
		write_reg(snpid_pkg::REG_GAIN_K, 32'h80000000);
		send(32'h12345678, 32'h00000000);
		send(32'h00000000, 32'h12345678);
		drain();

		fork
			begin
				hold_result = 1'b1;
				repeat (400) @(posedge clk);
				hold_result = 1'b0;
			end
			random_phase(6, 0);
		join
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			write_reg(snpid_pkg::REG_GAIN_K, $urandom_range(0, 3) == 0 ? rand_word()
				: 32'(int'($urandom_range(0, 262144)) - 131072));
			write_reg(snpid_pkg::REG_RATE_P,
				$urandom_range(0, 2) == 0 ? rand_word() : $urandom_range(0, 512));
			write_reg(snpid_pkg::REG_RATE_I,
				$urandom_range(0, 2) == 0 ? rand_word() : $urandom_range(0, 512));
			write_reg(snpid_pkg::REG_RATE_D,
				$urandom_range(0, 2) == 0 ? rand_word() : $urandom_range(0, 512));
			write_reg(snpid_pkg::REG_WINIT_P, ph == 5 ? 32'h0 : rand_weight());
			write_reg(snpid_pkg::REG_WINIT_I, ph == 5 ? 32'h0 : rand_weight());
			write_reg(snpid_pkg::REG_WINIT_D, ph == 5 ? 32'h0 : rand_weight());
			if (ph == 10) calm = 1'b1;
			random_phase(100, ph % 4 == 3);
			drain();
		end

		if (board.mismatches == 0 && board.drive_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
`default_nettype wire
